// File: hw/rtl/int8_max_pool_2d_defines.svh
// Assertion macros for the int8 max pooling block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef INT8_MAX_POOL_2D_DEFINES_SVH
`define INT8_MAX_POOL_2D_DEFINES_SVH

`define I8MP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define I8MP_ASSERT_IMPLIES(name, cond, expr, msg) \
  `I8MP_ASSERT(name, (cond) |-> (expr), msg)

`endif

// File: hw/rtl/i8mp_pkg.sv
// Shared constants, types and register codes of the int8 max pooling block.
// No dependencies.
package i8mp_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_KERNEL = 8;
  localparam int unsigned MAX_STRIDE = 8;
  localparam int unsigned LINE_ROWS  = MAX_KERNEL - 1;

  localparam int unsigned COL_W    = $clog2(MAX_WIDTH);
  localparam int unsigned SLOT_W   = $clog2(LINE_ROWS);
  localparam int unsigned RSAT_W   = $clog2(LINE_ROWS + 1);

  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned WIDTH_W  = 9;
  localparam int unsigned KERNEL_W = 4;
  localparam int unsigned STRIDE_W = 4;
  localparam int unsigned TOTAL_W  = 16;
  localparam int unsigned PHASE_W  = 3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic signed [7:0] pixel_t;

  localparam pixel_t PIXEL_MIN = 8'sh80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_HEIGHT,
    CFG_PLANE_WIDTH,
    CFG_KERNEL_HEIGHT,
    CFG_KERNEL_WIDTH,
    CFG_STRIDE_ROWS,
    CFG_STRIDE_COLS,
    CFG_PLANE_TOTAL
  } cfg_reg_e;

  typedef struct packed {
    logic emit;
    logic last_in_plane;
    logic last_in_batch;
  } win_flags_t;

endpackage

// File: hw/rtl/i8mp_if.sv
// Valid/ready stream interfaces for pixel requests and pooled results.
// Depends on i8mp_pkg.
interface i8mp_in_if import i8mp_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface i8mp_out_if import i8mp_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pooled_value;
  logic   last_in_plane;
  logic   last_in_batch;

  modport source (output valid, output pooled_value, output last_in_plane,
                  output last_in_batch, input ready);
  modport sink (input valid, input pooled_value, input last_in_plane,
                input last_in_batch, output ready);
endinterface

// File: hw/rtl/i8mp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i8mp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/int8_max_pool_2d.sv
// Streaming 2-D max pooling of signed 8-bit planes, top level.
// Depends on i8mp_pkg, i8mp_if, i8mp_ram and int8_max_pool_2d_defines.svh.
//
// Pixels enter on pixel_i in raster order, one request per ready cycle. Each
// window on the stride grid that lies wholly inside the plane gives one
// request on pooled_o when its bottom-right pixel is taken, with flags for
// the last window of a plane and of the batch. Other pixels give nothing.
// Users must write registers on the cfg port only while idle; not enforced.
// Throughput: one pixel per cycle unless pooled_o stalls, set by seven
// line banks of one read and one write port each, all read at the current
// column in the same cycle. Path: a result is registered in s1 (bank read),
// s2 (column max) and the output register (window max) before pooled_o.
// Reset: registers take their defaults, position counters clear, pipeline
// empties. The line banks need no clearing pass.
// Stall: while a result waits on pooled_o the whole pipeline holds and
// pixel_i.ready drops; it returns as soon as the result is taken.
`include "int8_max_pool_2d_defines.svh"

module int8_max_pool_2d import i8mp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  i8mp_in_if.sink               pixel_i,
  i8mp_out_if.source            pooled_o
);

  function automatic logic [KERNEL_W-1:0] clamp_small(logic [KERNEL_W-1:0] v,
                                                      logic [KERNEL_W-1:0] hi);
    logic [KERNEL_W-1:0] r;
    r = v;
    if (v == '0) r = KERNEL_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  logic [HEIGHT_W-1:0] cfg_h_q;
  logic [WIDTH_W-1:0]  cfg_w_q;
  logic [KERNEL_W-1:0] cfg_kh_q, cfg_kw_q;
  logic [STRIDE_W-1:0] cfg_sr_q, cfg_sc_q;
  logic [TOTAL_W-1:0]  cfg_tot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_h_q   <= HEIGHT_W'(28);
      cfg_w_q   <= WIDTH_W'(28);
      cfg_kh_q  <= KERNEL_W'(2);
      cfg_kw_q  <= KERNEL_W'(2);
      cfg_sr_q  <= STRIDE_W'(2);
      cfg_sc_q  <= STRIDE_W'(2);
      cfg_tot_q <= TOTAL_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_PLANE_HEIGHT:  cfg_h_q   <= cfg_data_i[HEIGHT_W-1:0];
        CFG_PLANE_WIDTH:   cfg_w_q   <= cfg_data_i[WIDTH_W-1:0];
        CFG_KERNEL_HEIGHT: cfg_kh_q  <= cfg_data_i[KERNEL_W-1:0];
        CFG_KERNEL_WIDTH:  cfg_kw_q  <= cfg_data_i[KERNEL_W-1:0];
        CFG_STRIDE_ROWS:   cfg_sr_q  <= cfg_data_i[STRIDE_W-1:0];
        CFG_STRIDE_COLS:   cfg_sc_q  <= cfg_data_i[STRIDE_W-1:0];
        CFG_PLANE_TOTAL:   cfg_tot_q <= cfg_data_i[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [HEIGHT_W-1:0] h_eff;
  logic [WIDTH_W-1:0]  w_eff;
  logic [KERNEL_W-1:0] kh_eff, kw_eff;
  logic [STRIDE_W-1:0] sh_eff, sw_eff;
  logic [TOTAL_W-1:0]  tot_eff;

  assign h_eff   = (cfg_h_q == '0) ? HEIGHT_W'(1) : cfg_h_q;
  assign w_eff   = (cfg_w_q == '0) ? WIDTH_W'(1) :
                   (cfg_w_q > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : cfg_w_q;
  assign kh_eff  = clamp_small(cfg_kh_q, KERNEL_W'(MAX_KERNEL));
  assign kw_eff  = clamp_small(cfg_kw_q, KERNEL_W'(MAX_KERNEL));
  assign sh_eff  = clamp_small(cfg_sr_q, STRIDE_W'(MAX_STRIDE));
  assign sw_eff  = clamp_small(cfg_sc_q, STRIDE_W'(MAX_STRIDE));
  assign tot_eff = (cfg_tot_q == '0) ? TOTAL_W'(1) : cfg_tot_q;

  logic advance, accept;
  logic out_valid_q;

  assign advance = !out_valid_q || pooled_o.ready;
  assign accept  = pixel_i.valid && advance;
  assign pixel_i.ready = advance;

  logic [COL_W-1:0]    col_q, col_d, col_cur;
  logic [HEIGHT_W-1:0] row_q, row_d, row_cur, row_inc;
  logic [PHASE_W-1:0]  cph_q, cph_d, cph_cur, rph_q, rph_d, rph_cur;
  logic [SLOT_W-1:0]   slot_q, slot_d, slot_cur;
  logic [TOTAL_W-1:0]  pd_q, pd_d;
  logic [TOTAL_W:0]    pd_inc;
  logic [WIDTH_W-1:0]  col_inc;
  logic                col_wrap, row_wrap, col_full, row_full;
  win_flags_t          flags_a;

  assign col_wrap = WIDTH_W'(col_q) >= w_eff;
  assign row_wrap = row_q >= h_eff;
  assign col_cur  = col_wrap ? '0 : col_q;
  assign cph_cur  = col_wrap ? '0 : cph_q;
  assign row_cur  = row_wrap ? '0 : row_q;
  assign rph_cur  = row_wrap ? '0 : rph_q;
  assign slot_cur = row_wrap ? '0 : slot_q;
  assign col_inc  = WIDTH_W'(col_cur) + WIDTH_W'(1);
  assign row_inc  = row_cur + HEIGHT_W'(1);
  assign col_full = col_inc >= WIDTH_W'(kw_eff);
  assign row_full = row_inc >= HEIGHT_W'(kh_eff);
  assign pd_inc   = (TOTAL_W+1)'(pd_q) + (TOTAL_W+1)'(1);

  assign flags_a.emit = row_full && (rph_cur == '0) && col_full && (cph_cur == '0);
  assign flags_a.last_in_plane =
      ((HEIGHT_W+1)'(row_cur) + (HEIGHT_W+1)'(sh_eff) >= (HEIGHT_W+1)'(h_eff)) &&
      (WIDTH_W'(col_cur) + WIDTH_W'(sw_eff) >= w_eff);
  assign flags_a.last_in_batch =
      flags_a.last_in_plane && (pd_inc >= (TOTAL_W+1)'(tot_eff));

  always_comb begin
    col_d  = col_q;
    cph_d  = cph_q;
    row_d  = row_q;
    rph_d  = rph_q;
    slot_d = slot_q;
    pd_d   = pd_q;
    if (accept) begin
      cph_d  = cph_cur;
      rph_d  = rph_cur;
      row_d  = row_cur;
      slot_d = slot_cur;
      if (col_full) begin
        cph_d = (STRIDE_W'(cph_cur) + STRIDE_W'(1) >= sw_eff) ? '0 : cph_cur + PHASE_W'(1);
      end
      col_d = col_inc[COL_W-1:0];
      if (col_inc >= w_eff) begin
        col_d = '0;
        cph_d = '0;
        if (row_full) begin
          rph_d = (STRIDE_W'(rph_cur) + STRIDE_W'(1) >= sh_eff) ? '0 : rph_cur + PHASE_W'(1);
        end
        row_d  = row_inc;
        slot_d = (slot_cur == SLOT_W'(LINE_ROWS - 1)) ? '0 : slot_cur + SLOT_W'(1);
        if (row_inc >= h_eff) begin
          row_d  = '0;
          rph_d  = '0;
          slot_d = '0;
          pd_d   = pd_inc[TOTAL_W-1:0];
          if (pd_d >= tot_eff) pd_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      cph_q  <= '0;
      row_q  <= '0;
      rph_q  <= '0;
      slot_q <= '0;
      pd_q   <= '0;
    end else begin
      col_q  <= col_d;
      cph_q  <= cph_d;
      row_q  <= row_d;
      rph_q  <= rph_d;
      slot_q <= slot_d;
      pd_q   <= pd_d;
    end
  end

  pixel_t rdata [LINE_ROWS];

  for (genvar b = 0; b < LINE_ROWS; b++) begin : g_bank
    i8mp_ram #(
      .Width ($bits(pixel_t)),
      .Depth (MAX_WIDTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (accept && (slot_cur == SLOT_W'(b))),
      .waddr_i (col_cur),
      .wdata_i (pixel_i.pixel),
      .re_i    (accept),
      .raddr_i (col_cur),
      .rdata_o (rdata[b])
    );
  end

  logic              s1_valid_q;
  pixel_t            s1_pix_q;
  logic [RSAT_W-1:0] s1_rsat_q;
  logic [SLOT_W-1:0] s1_slot_q;
  win_flags_t        s1_flags_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= pixel_i.pixel;
      s1_rsat_q  <= (row_cur >= HEIGHT_W'(LINE_ROWS)) ? RSAT_W'(LINE_ROWS)
                                                     : row_cur[RSAT_W-1:0];
      s1_slot_q  <= slot_cur;
      s1_flags_q <= flags_a;
    end
  end

  pixel_t            col_max;
  logic [SLOT_W-1:0] bank_idx;

  always_comb begin
    col_max  = s1_pix_q;
    bank_idx = '0;
    for (int k = 1; k < MAX_KERNEL; k++) begin
      if ((KERNEL_W'(k) < kh_eff) && (RSAT_W'(k) <= s1_rsat_q)) begin
        bank_idx = (s1_slot_q >= SLOT_W'(k)) ? s1_slot_q - SLOT_W'(k)
                                             : s1_slot_q + SLOT_W'(LINE_ROWS - k);
        if (rdata[bank_idx] > col_max) col_max = rdata[bank_idx];
      end
    end
  end

  logic       s2_valid_q;
  pixel_t     cmw_q [MAX_KERNEL];
  win_flags_t s2_flags_q;

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      for (int i = 0; i < MAX_KERNEL - 1; i++) begin
        cmw_q[i] <= cmw_q[i+1];
      end
      cmw_q[MAX_KERNEL-1] <= col_max;
      s2_flags_q <= s1_flags_q;
    end
  end

  pixel_t best;

  always_comb begin
    best = PIXEL_MIN;
    for (int k = 0; k < MAX_KERNEL; k++) begin
      if ((KERNEL_W'(k) + kw_eff >= KERNEL_W'(MAX_KERNEL)) && (cmw_q[k] > best)) begin
        best = cmw_q[k];
      end
    end
  end

  pixel_t out_value_q;
  logic   out_lp_q, out_lb_q;

  always_ff @(posedge clk_i) begin
    if (advance && s2_valid_q && s2_flags_q.emit) begin
      out_value_q <= best;
      out_lp_q    <= s2_flags_q.last_in_plane;
      out_lb_q    <= s2_flags_q.last_in_batch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q && s2_flags_q.emit;
    end
  end

  assign pooled_o.valid         = out_valid_q;
  assign pooled_o.pooled_value  = out_value_q;
  assign pooled_o.last_in_plane = out_lp_q;
  assign pooled_o.last_in_batch = out_lb_q;

  `I8MP_ASSERT_IMPLIES(a_batch_implies_plane, out_valid_q && out_lb_q, out_lp_q,
                       "batch end without plane end")
  `I8MP_ASSERT_IMPLIES(a_slot_range, 1'b1, slot_q <= SLOT_W'(LINE_ROWS - 1),
                       "line slot out of range")
  `I8MP_ASSERT_IMPLIES(a_col_phase, col_q == '0, cph_q == '0,
                       "column phase not cleared at row start")
  `I8MP_ASSERT_IMPLIES(a_row_phase, row_q == '0, (rph_q == '0) && (slot_q == '0),
                       "row state not cleared at plane start")
  `I8MP_ASSERT(a_stall_holds, out_valid_q && !pooled_o.ready |=>
               $stable(s1_valid_q) && $stable(s2_valid_q) && $stable(s2_flags_q),
               "pipeline moved during stall")

endmodule
